### src/avpqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AV packet queue scheduler package
// Shared types, codes and port widths of the audio/video packet scheduler.
// ----------------------------------------------------------------------------
package avpqs_pkg;

    // Stream port widths.
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 5;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 6;

    // Result field widths.
    localparam int LEVEL_W = 6;
    localparam int TOTAL_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_DROP_UNTIL_KEY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_LIMIT    = 1'b1;

    // Queue limit after reset.
    localparam logic [CFG_DATA_W-1:0] QUEUE_LIMIT_RST = 6'd32;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_DEQ    = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_QUEUED      = 3'd0,
        ST_QUEUED_DROP = 3'd1,
        ST_NEW_DROPPED = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_SEND        = 3'd4,
        ST_KEY_DROP    = 3'd5,
        ST_CONN_FAIL   = 3'd6,
        ST_REPORT      = 3'd7
    } t_status;

    // One packet descriptor as held in a queue.
    typedef struct packed {
        logic        key;
        logic [23:0] bytes;
        logic [15:0] tag;
        logic [47:0] pts;
    } t_entry;

endpackage
`default_nettype wire

### src/avpqs_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AV packet queue ring buffer
// Ring FIFO of packet descriptors with a registered head entry. Any number
// of entries can be popped and one pushed in the same cycle.
// ----------------------------------------------------------------------------
module avpqs_ring
    import avpqs_pkg::*;
#(
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [CW-1:0] i_pop_cnt,
    input  wire t_entry        i_wdata,
    output logic [CW-1:0]      o_count,
    output t_entry             o_head
);

    t_entry          r_mem [DEPTH];
    t_entry          r_head_data;
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   n_head;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   remain;
    logic [AW-1:0]   tail;
    logic [CW:0]     head_sum;
    logic [CW:0]     head_wrap;
    logic [CW:0]     tail_sum;
    logic [CW:0]     tail_wrap;

    // Advance the head past the popped entries, then place the tail after
    // the entries that remain.
    always_comb begin
        remain    = r_count - i_pop_cnt;
        head_sum  = (CW + 1)'(r_head) + {1'b0, i_pop_cnt};
        head_wrap = (head_sum >= (CW + 1)'(DEPTH)) ? head_sum - (CW + 1)'(DEPTH) : head_sum;
        n_head    = head_wrap[AW-1:0];
        tail_sum  = (CW + 1)'(n_head) + {1'b0, remain};
        tail_wrap = (tail_sum >= (CW + 1)'(DEPTH)) ? tail_sum - (CW + 1)'(DEPTH) : tail_sum;
        tail      = tail_wrap[AW-1:0];
        n_count   = remain + CW'(i_push);
    end

    // Head pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Descriptor memory; the new head entry is read ahead, and a push into
    // an empty queue goes straight to the head register.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_wdata;
        end
        if (i_push && (tail == n_head)) begin
            r_head_data <= i_wdata;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_count = r_count;
    assign o_head  = r_head_data;

endmodule
`default_nettype wire

### src/av_packet_queue_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A request accepted into the input register passes to the output register
// once that register is empty or being drained.
// Throughput: one request per cycle while the result stream is not stalled;
// the head and tail pointer logic of the two ring buffers does every update.
// Reset: synchronous, active low; both queues empty, link down, counters zero.
// The descriptor memories are not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// AV packet queue scheduler core
// Audio and video descriptor queues merged by timestamp toward one link,
// with drop policies for full queues and keyframe resynchronization.
// ----------------------------------------------------------------------------
module av_packet_queue_scheduler_core
    import avpqs_pkg::*;
#(
    parameter int RING_DEPTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration writes.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // pts[47:0], packet_tag[63:48], byte_count[87:64], link_ok[88], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0], is_audio[2], is_key[3]
    input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_tag[15:0], out_pts[63:16], out_bytes[87:64], link_up[88],
    // awaiting_key[89], video_level[95:90], audio_level[101:96],
    // drop_total[133:102], fail_total[165:134], zero fill
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // status[2:0], out_is_audio[3], out_is_key[4]
    output logic [M_TUSER_W-1:0]       m_axis_tuser
);

    localparam int CW = $clog2(RING_DEPTH + 1);

    // Configuration registers.
    logic                  r_drop_until_key;
    logic [CFG_DATA_W-1:0] r_queue_limit;

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_in_kind;
    logic        r_in_audio;
    logic        r_in_link_ok;
    t_entry      r_in_entry;

    // Scheduler state.
    logic                r_link;
    logic                n_link;
    logic                r_keywait;
    logic                n_keywait;
    logic [TOTAL_W-1:0]  r_drop;
    logic [TOTAL_W-1:0]  n_drop;
    logic [TOTAL_W-1:0]  r_fail;
    logic [TOTAL_W-1:0]  n_fail;

    // Output register.
    logic     r_out_valid;
    t_status  r_out_status;
    t_status  n_status;
    t_entry   r_out_pkt;
    t_entry   n_pkt;
    logic     r_out_audio;
    logic     n_pkt_audio;

    // Ring buffer connections.
    logic [CW-1:0] v_count;
    logic [CW-1:0] a_count;
    t_entry        v_head;
    t_entry        a_head;
    logic          v_push;
    logic          a_push;
    logic [CW-1:0] v_pop;
    logic [CW-1:0] a_pop;

    // Request datapath.
    logic          fire;
    logic          out_free;
    logic [CW-1:0] lim;
    logic [CW-1:0] tcount;
    logic          full;
    logic [CW-1:0] purge;
    logic          take_audio;
    t_entry        sel;
    logic [CW-1:0] drop_add;
    logic          fail_inc;
    logic [TOTAL_W:0] drop_sum;

    // Handshake: the input register moves on whenever the output register
    // is empty or being drained.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_until_key <= 1'b0;
            r_queue_limit    <= QUEUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DROP_UNTIL_KEY: begin
                    r_drop_until_key <= i_cfg_wdata[0];
                end
                CFG_QUEUE_LIMIT: begin
                    r_queue_limit <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind        <= s_axis_tuser[1:0];
            r_in_audio       <= s_axis_tuser[2];
            r_in_entry.key   <= s_axis_tuser[3];
            r_in_entry.pts   <= s_axis_tdata[47:0];
            r_in_entry.tag   <= s_axis_tdata[63:48];
            r_in_entry.bytes <= s_axis_tdata[87:64];
            r_in_link_ok     <= s_axis_tdata[88];
        end
    end

    // Video and audio queues.
    avpqs_ring #(
        .DEPTH (RING_DEPTH)
    ) u_video (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fire && v_push),
        .i_pop_cnt    (fire ? v_pop : '0),
        .i_wdata      (r_in_entry),
        .o_count      (v_count),
        .o_head       (v_head)
    );

    avpqs_ring #(
        .DEPTH (RING_DEPTH)
    ) u_audio (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fire && a_push),
        .i_pop_cnt    (fire ? a_pop : '0),
        .i_wdata      (r_in_entry),
        .o_count      (a_count),
        .o_head       (a_head)
    );

    // Limit in use: zero or anything above the storage means full storage.
    always_comb begin
        if ((r_queue_limit == '0) || (int'(r_queue_limit) > RING_DEPTH)) begin
            lim = CW'(RING_DEPTH);
        end else begin
            lim = CW'(r_queue_limit);
        end
    end

    // Queue selection for enqueue and dequeue.
    always_comb begin
        tcount = r_in_audio ? a_count : v_count;
        full   = (tcount >= lim);
        purge  = tcount - lim + CW'(1);
        if (v_count == '0) begin
            take_audio = 1'b1;
        end else if ((a_count == '0) || r_keywait) begin
            take_audio = 1'b0;
        end else begin
            take_audio = (a_head.pts < v_head.pts);
        end
        sel = take_audio ? a_head : v_head;
    end

    // Request decode and state update.
    always_comb begin
        n_status    = ST_EMPTY;
        n_pkt       = '0;
        n_pkt_audio = 1'b0;
        n_link      = r_link;
        n_keywait   = r_keywait;
        drop_add    = '0;
        fail_inc    = 1'b0;
        v_push      = 1'b0;
        a_push      = 1'b0;
        v_pop       = '0;
        a_pop       = '0;
        case (t_kind'(r_in_kind))
            KIND_ENQ: begin
                n_status = ST_QUEUED;
                if (full) begin
                    if (!r_in_audio && !r_in_entry.key) begin
                        // Non-key video into a full queue is refused.
                        n_status = ST_NEW_DROPPED;
                        drop_add = CW'(1);
                    end else begin
                        // Drop oldest entries until one slot is free.
                        n_status = ST_QUEUED_DROP;
                        drop_add = purge;
                        if (r_in_audio) begin
                            a_pop = purge;
                        end else begin
                            v_pop = purge;
                        end
                    end
                end
                if (n_status != ST_NEW_DROPPED) begin
                    a_push = r_in_audio;
                    v_push = !r_in_audio;
                end
            end
            KIND_DEQ: begin
                if ((v_count != '0) || (a_count != '0)) begin
                    n_pkt       = sel;
                    n_pkt_audio = take_audio;
                    n_status    = ST_SEND;
                    if (take_audio) begin
                        a_pop = CW'(1);
                    end else begin
                        v_pop = CW'(1);
                    end
                    // Link down: this dequeue carries a connect attempt.
                    if (!r_link) begin
                        if (r_in_link_ok) begin
                            n_link    = 1'b1;
                            n_keywait = r_drop_until_key;
                        end else begin
                            n_status = ST_CONN_FAIL;
                        end
                    end
                    // Waiting for a keyframe: drop anything else.
                    if ((n_status == ST_SEND) && n_keywait) begin
                        if (!sel.key) begin
                            drop_add = CW'(1);
                            n_status = ST_KEY_DROP;
                        end else begin
                            n_keywait = 1'b0;
                        end
                    end
                end
            end
            KIND_REPORT: begin
                n_status = ST_REPORT;
                if (!r_in_link_ok) begin
                    n_link    = 1'b0;
                    n_keywait = r_drop_until_key;
                    fail_inc  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Saturating counters.
    always_comb begin
        drop_sum = {1'b0, r_drop} + (TOTAL_W + 1)'(drop_add);
        n_drop   = drop_sum[TOTAL_W] ? '1 : drop_sum[TOTAL_W-1:0];
        if (fail_inc && (r_fail != '1)) begin
            n_fail = r_fail + TOTAL_W'(1);
        end else begin
            n_fail = r_fail;
        end
    end

    // Scheduler state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link      <= 1'b0;
            r_keywait   <= 1'b0;
            r_drop      <= '0;
            r_fail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_link    <= n_link;
                r_keywait <= n_keywait;
                r_drop    <= n_drop;
                r_fail    <= n_fail;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= n_status;
            r_out_pkt    <= n_pkt;
            r_out_audio  <= n_pkt_audio;
        end
    end

    // State registers and queue counts change only together with the
    // output register, so they are the result's status fields.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_pkt.key, r_out_audio, r_out_status};
    assign m_axis_tdata  = {2'b00, r_fail, r_drop,
                            LEVEL_W'(a_count), LEVEL_W'(v_count),
                            r_keywait, r_link,
                            r_out_pkt.bytes, r_out_pkt.pts, r_out_pkt.tag};

endmodule
`default_nettype wire

### src/avpqs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AV packet queue scheduler checker
// Port-level checks of the result stream, bound to the scheduler core.
// ----------------------------------------------------------------------------
module avpqs_checker
    import avpqs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic [2:0] status;
    logic       link_up;
    logic       awaiting_key;
    logic       pkt_zero;

    assign status       = m_axis_tuser[2:0];
    assign link_up      = m_axis_tdata[88];
    assign awaiting_key = m_axis_tdata[89];
    assign pkt_zero     = (m_axis_tdata[87:0] == '0) && (m_axis_tuser[4:3] == 2'b00);

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // A packet is only sent on an established link.
    a_send_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == ST_SEND)) |-> link_up)
        else $error("send with link down");

    // A failed connect leaves the link down; a key drop keeps the key wait.
    a_fail_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((status == ST_CONN_FAIL) ||
                           ((status == ST_KEY_DROP) && !awaiting_key))) |-> !link_up &&
        (status == ST_CONN_FAIL))
        else $error("link or key wait flag inconsistent with status");

    // Only dequeue results carry a packet.
    a_pkt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status != ST_SEND) && (status != ST_KEY_DROP) &&
         (status != ST_CONN_FAIL)) |-> pkt_zero)
        else $error("packet fields set on a non-dequeue result");

endmodule

bind av_packet_queue_scheduler_core avpqs_checker u_avpqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### verif/tb_av_packet_queue_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AV packet queue scheduler testbench
// Drives enqueue, dequeue and send-report requests into the scheduler core,
// predicts every result with an independent model of the two descriptor
// queues and the link state, and compares each result field by field. The
// run steps through several register settings, random idling on both sides,
// a long back-pressure stretch and a pause that lets the block drain.
// ----------------------------------------------------------------------------
module tb_av_packet_queue_scheduler_core;
    import avpqs_pkg::*;

    localparam int QDEPTH = 32;
    // Request kind outside the defined set; the block must ignore it.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [47:0] PTS_MAX = '1;
    localparam int IDLE_PCT = 23;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_audio;
        logic        is_key;
        logic [47:0] pts;
        logic [15:0] tag;
        logic [23:0] nbytes;
        logic        link_ok;
    } t_sched_req;

    typedef struct packed {
        t_status            status;
        logic [15:0]        tag;
        logic               is_audio;
        logic               is_key;
        logic [47:0]        pts;
        logic [23:0]        nbytes;
        logic               link_up;
        logic               awaiting_key;
        logic [LEVEL_W-1:0] video_level;
        logic [LEVEL_W-1:0] audio_level;
        logic [TOTAL_W-1:0] drop_total;
        logic [TOTAL_W-1:0] fail_total;
    } t_sched_res;

    // DUT signals; every input is known from time zero.
    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    // Stimulus and scoreboard bookkeeping.
    t_sched_req  pending_reqs [$];
    t_sched_res  awaited_results [$];
    t_sched_req  offered_rq;
    int unsigned queued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned settings_used = 0;
    int unsigned status_seen [8];
    bit          no_idle = 1'b0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    logic [47:0] pts_clock = '0;
    logic [47:0] last_pts = '0;

    // Shadow copy of the scheduler state and its registers.
    t_entry             video_slots [QDEPTH];
    t_entry             audio_slots [QDEPTH];
    int unsigned        video_head = 0;
    int unsigned        audio_head = 0;
    int unsigned        video_fill = 0;
    int unsigned        audio_fill = 0;
    bit                 link_state = 1'b0;
    bit                 key_wait = 1'b0;
    logic [TOTAL_W-1:0] drops_seen = '0;
    logic [TOTAL_W-1:0] fails_seen = '0;
    bit                 cfg_key_resync = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_limit = QUEUE_LIMIT_RST;

    av_packet_queue_scheduler_core #(
        .RING_DEPTH(QDEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] c);
        return (c == {TOTAL_W{1'b1}}) ? c : c + TOTAL_W'(1);
    endfunction

    // Removes the head entry of one queue.
    function automatic void drop_oldest(input bit audio);
        if (audio && audio_fill != 0) begin
            audio_head = (audio_head + 1) % QDEPTH;
            audio_fill--;
        end else if (!audio && video_fill != 0) begin
            video_head = (video_head + 1) % QDEPTH;
            video_fill--;
        end
    endfunction

    // Appends an entry at the tail of one queue.
    function automatic void append_entry(input bit audio, input t_entry e);
        if (audio && audio_fill < QDEPTH) begin
            audio_slots[(audio_head + audio_fill) % QDEPTH] = e;
            audio_fill++;
        end else if (!audio && video_fill < QDEPTH) begin
            video_slots[(video_head + video_fill) % QDEPTH] = e;
            video_fill++;
        end
    endfunction

    // Applies one request to the shadow state and returns the expected result.
    function automatic t_sched_res schedule_request(input t_sched_req rq);
        t_sched_res  r;
        int unsigned lim;
        bit          take_audio;
        t_entry      e;
        r = '0;
        r.status = ST_EMPTY;
        lim = (cfg_limit == 0 || cfg_limit > QDEPTH) ? QDEPTH : int'(cfg_limit);
        case (rq.kind)
            KIND_ENQ: begin
                e.key = rq.is_key;
                e.bytes = rq.nbytes;
                e.tag = rq.tag;
                e.pts = rq.pts;
                r.status = ST_QUEUED;
                if ((rq.is_audio ? audio_fill : video_fill) >= lim) begin
                    // Full queue: non-key video is refused, anything else
                    // pushes out old entries until one slot is free.
                    if (!rq.is_audio && !rq.is_key) begin
                        drops_seen = sat_inc(drops_seen);
                        r.status = ST_NEW_DROPPED;
                    end else begin
                        while ((rq.is_audio ? audio_fill : video_fill) >= lim) begin
                            drop_oldest(rq.is_audio);
                            drops_seen = sat_inc(drops_seen);
                        end
                        r.status = ST_QUEUED_DROP;
                    end
                end
                if (r.status != ST_NEW_DROPPED)
                    append_entry(rq.is_audio, e);
            end
            KIND_DEQ: begin
                if (video_fill != 0 || audio_fill != 0) begin
                    // Video goes first while a keyframe is awaited; otherwise
                    // the older timestamp wins and video wins a tie.
                    if (video_fill == 0)
                        take_audio = 1'b1;
                    else if (audio_fill == 0 || key_wait)
                        take_audio = 1'b0;
                    else
                        take_audio = audio_slots[audio_head].pts <
                                     video_slots[video_head].pts;
                    e = take_audio ? audio_slots[audio_head] : video_slots[video_head];
                    drop_oldest(take_audio);
                    r.tag = e.tag;
                    r.nbytes = e.bytes;
                    r.is_key = e.key;
                    r.pts = e.pts;
                    r.is_audio = take_audio;
                    r.status = ST_SEND;
                    if (!link_state) begin
                        if (rq.link_ok) begin
                            link_state = 1'b1;
                            key_wait = cfg_key_resync;
                        end else begin
                            r.status = ST_CONN_FAIL;
                        end
                    end
                    if (r.status == ST_SEND && key_wait) begin
                        if (!e.key) begin
                            drops_seen = sat_inc(drops_seen);
                            r.status = ST_KEY_DROP;
                        end else begin
                            key_wait = 1'b0;
                        end
                    end
                end
            end
            KIND_REPORT: begin
                if (!rq.link_ok) begin
                    link_state = 1'b0;
                    key_wait = cfg_key_resync;
                    fails_seen = sat_inc(fails_seen);
                end
                r.status = ST_REPORT;
            end
            default: ;
        endcase
        r.link_up = link_state;
        r.awaiting_key = key_wait;
        r.video_level = video_fill[LEVEL_W-1:0];
        r.audio_level = audio_fill[LEVEL_W-1:0];
        r.drop_total = drops_seen;
        r.fail_total = fails_seen;
        return r;
    endfunction

    function automatic t_sched_req enq_req(input bit audio, input bit key,
                                           input logic [47:0] pts,
                                           input logic [15:0] tag,
                                           input logic [23:0] nbytes);
        t_sched_req rq;
        rq = '0;
        rq.kind = KIND_ENQ;
        rq.is_audio = audio;
        rq.is_key = key;
        rq.pts = pts;
        rq.tag = tag;
        rq.nbytes = nbytes;
        return rq;
    endfunction

    function automatic t_sched_req cmd_req(input logic [1:0] kind, input bit ok);
        t_sched_req rq;
        rq = '0;
        rq.kind = kind;
        rq.link_ok = ok;
        return rq;
    endfunction

    // Random request; timestamps mostly advance with jitter, with ties and
    // extremes mixed in so that the merge order is exercised.
    function automatic t_sched_req random_request(input int enq_pct);
        t_sched_req rq;
        int         roll;
        int         deq_end;
        rq.is_audio = 1'($urandom_range(0, 1));
        rq.is_key = ($urandom_range(0, 99) < 20);
        rq.tag = 16'($urandom);
        rq.nbytes = 24'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            pts_clock = pts_clock + 48'($urandom_range(0, 1500));
            rq.pts = pts_clock + 48'($urandom_range(0, 3000));
        end else if (roll < 80) begin
            rq.pts = last_pts;
        end else if (roll < 95) begin
            rq.pts = {16'($urandom), 32'($urandom)};
        end else begin
            rq.pts = $urandom_range(0, 1) ? PTS_MAX : '0;
        end
        last_pts = rq.pts;
        deq_end = enq_pct + (97 - enq_pct) * 7 / 10;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
            rq.kind = KIND_ENQ;
        else if (roll < deq_end)
            rq.kind = KIND_DEQ;
        else if (roll < 97)
            rq.kind = KIND_REPORT;
        else
            rq.kind = KIND_SPARE;
        if (rq.kind == KIND_DEQ)
            rq.link_ok = ($urandom_range(0, 99) < 80);
        else if (rq.kind == KIND_REPORT)
            rq.link_ok = ($urandom_range(0, 99) < 75);
        else
            rq.link_ok = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic void queue_item(input t_sched_req rq);
        pending_reqs.push_back(rq);
        queued_total++;
    endfunction

    function automatic void queue_random(input int count, input int enq_pct);
        for (int k = 0; k < count; k++)
            queue_item(random_request(enq_pct));
    endfunction

    // Returns once every queued request has been taken and answered.
    task automatic wait_drained();
        while (accepted_total != queued_total || awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        if (addr == CFG_DROP_UNTIL_KEY)
            cfg_key_resync = value[0];
        else
            cfg_limit = value;
        settings_used++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic compare_field(input string fname, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (want_v !== got_v) begin
            if (mismatch_count < 10)
                $display("MISMATCH result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, fname, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Request driver: offers queued requests and predicts each accepted one.
    always @(posedge i_clk) begin : drive_requests
        bit take_next;
        bit offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            take_next = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(schedule_request(offered_rq));
                accepted_total++;
                take_next = 1'b1;
            end
            if (take_next) begin
                offer = (pending_reqs.size() != 0) &&
                        (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
                if (offer) begin
                    offered_rq = pending_reqs.pop_front();
                    s_axis_tdata <= {7'b0, offered_rq.link_ok, offered_rq.nbytes,
                                     offered_rq.tag, offered_rq.pts};
                    s_axis_tuser <= {offered_rq.is_key, offered_rq.is_audio,
                                     offered_rq.kind};
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // Result monitor: checks every accepted result and paces tready.
    always @(posedge i_clk) begin : watch_results
        t_sched_res got;
        t_sched_res want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser[2:0]);
            got.is_audio = m_axis_tuser[3];
            got.is_key = m_axis_tuser[4];
            got.tag = m_axis_tdata[15:0];
            got.pts = m_axis_tdata[63:16];
            got.nbytes = m_axis_tdata[87:64];
            got.link_up = m_axis_tdata[88];
            got.awaiting_key = m_axis_tdata[89];
            got.video_level = m_axis_tdata[95:90];
            got.audio_level = m_axis_tdata[101:96];
            got.drop_total = m_axis_tdata[133:102];
            got.fail_total = m_axis_tdata[165:134];
            if (awaited_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("MISMATCH: unexpected result, status %0d", got.status);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                status_seen[want.status]++;
                compare_field("status", 64'(want.status), 64'(got.status));
                compare_field("out_tag", 64'(want.tag), 64'(got.tag));
                compare_field("out_is_audio", 64'(want.is_audio), 64'(got.is_audio));
                compare_field("out_is_key", 64'(want.is_key), 64'(got.is_key));
                compare_field("out_pts", 64'(want.pts), 64'(got.pts));
                compare_field("out_bytes", 64'(want.nbytes), 64'(got.nbytes));
                compare_field("link_up", 64'(want.link_up), 64'(got.link_up));
                compare_field("awaiting_key", 64'(want.awaiting_key),
                              64'(got.awaiting_key));
                compare_field("video_level", 64'(want.video_level),
                              64'(got.video_level));
                compare_field("audio_level", 64'(want.audio_level),
                              64'(got.audio_level));
                compare_field("drop_total", 64'(want.drop_total), 64'(got.drop_total));
                compare_field("fail_total", 64'(want.fail_total), 64'(got.fail_total));
            end
            results_seen++;
        end
        // A requested hold-off keeps tready low for a counted stretch.
        if (hold_left != 0) begin
            hold_left--;
        end else if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        m_axis_tready <= (hold_left == 0) &&
                         (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Test sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue, reports on a down link, and an undefined kind.
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_REPORT, 1'b1));
        queue_item(cmd_req(KIND_REPORT, 1'b0));
        queue_item('{KIND_SPARE, 1'b1, 1'b1, PTS_MAX, 16'hFFFF, 24'hFFFFFF, 1'b1});
        // Field extremes, then a connect failure, a connect, and a tie.
        queue_item(enq_req(1'b0, 1'b0, 48'd5000, 16'h1234, 24'h000100));
        queue_item(enq_req(1'b0, 1'b1, PTS_MAX, 16'hFFFF, 24'hFFFFFF));
        queue_item(enq_req(1'b1, 1'b0, 48'd0, 16'h0000, 24'h000000));
        queue_item(enq_req(1'b1, 1'b1, 48'd5000, 16'h5A5A, 24'h00ABCD));
        queue_item(cmd_req(KIND_DEQ, 1'b0));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        wait_drained();

        // Keyframe resync after a failed send: video first, non-key dropped.
        write_register(CFG_DROP_UNTIL_KEY, 6'd1);
        queue_item(cmd_req(KIND_REPORT, 1'b0));
        queue_item(enq_req(1'b0, 1'b0, 48'd300, 16'h0301, 24'd1500));
        queue_item(enq_req(1'b0, 1'b1, 48'd400, 16'h0402, 24'd9000));
        queue_item(enq_req(1'b1, 1'b0, 48'd100, 16'h0103, 24'd200));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        queue_item(cmd_req(KIND_DEQ, 1'b1));
        wait_drained();

        queue_random(200, 50);
        wait_drained();

        // Single-entry queues.
        write_register(CFG_QUEUE_LIMIT, 6'd1);
        queue_random(120, 50);
        wait_drained();

        // Back-pressure: the receiver stalls while requests keep coming.
        write_register(CFG_DROP_UNTIL_KEY, 6'd0);
        write_register(CFG_QUEUE_LIMIT, 6'd4);
        no_idle = 1'b1;
        hold_request = HOLD_CYCLES;
        queue_random(100, 50);
        wait_drained();

        // A long stretch with neither side idling.
        write_register(CFG_DROP_UNTIL_KEY, 6'd1);
        write_register(CFG_QUEUE_LIMIT, 6'd8);
        queue_random(200, 50);
        wait_drained();
        no_idle = 1'b0;

        // Fill at full capacity, then lower the limit below the fill.
        write_register(CFG_QUEUE_LIMIT, 6'd32);
        queue_random(20, 100);
        wait_drained();
        write_register(CFG_QUEUE_LIMIT, 6'd2);
        queue_item(enq_req(1'b1, 1'b0, 48'd7000, 16'hA001, 24'd64));
        queue_item(enq_req(1'b0, 1'b1, 48'd7000, 16'hA002, 24'd128));
        queue_item(enq_req(1'b0, 1'b0, 48'd7100, 16'hA003, 24'd256));
        wait_drained();

        // Limit zero stands for full depth; enqueue-heavy to reach it.
        write_register(CFG_QUEUE_LIMIT, 6'd0);
        queue_random(150, 62);
        wait_drained();

        // A limit beyond the depth saturates.
        write_register(CFG_DROP_UNTIL_KEY, 6'd0);
        write_register(CFG_QUEUE_LIMIT, 6'd63);
        queue_random(150, 45);
        wait_drained();

        write_register(CFG_DROP_UNTIL_KEY, 6'd1);
        write_register(CFG_QUEUE_LIMIT, 6'd5);
        queue_random(150, 50);
        wait_drained();

        repeat (4) @(posedge i_clk);
        $display("Run covered %0d requests over %0d register writes: %0d sends, %0d key drops,",
                 accepted_total, settings_used, status_seen[ST_SEND],
                 status_seen[ST_KEY_DROP]);
        $display("%0d connect failures, %0d full-queue drops, %0d refusals; %0d field errors.",
                 status_seen[ST_CONN_FAIL], status_seen[ST_QUEUED_DROP],
                 status_seen[ST_NEW_DROPPED], mismatch_count);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Timeout: %0d of %0d requests accepted, %0d results outstanding.",
                 accepted_total, queued_total, awaited_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
src/avpqs_pkg.sv
src/avpqs_ring.sv
src/av_packet_queue_scheduler_core.sv
src/avpqs_checker.sv
verif/tb_av_packet_queue_scheduler_core.sv
